FILE: hw/rtl/ajm_pkg.sv
`timescale 1ns / 1ps

package ajm_pkg;

  localparam int unsigned PosW    = 24;
  localparam int unsigned DtW     = 20;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SqW     = 2 * PosW + 1;
  localparam int unsigned RootW   = PosW + 1;
  localparam int unsigned CntW    = $clog2(RootW);

  localparam logic [CfgIdxW-1:0] CfgMinFlight = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSettle    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxHeight = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxDist   = 2'd3;

  localparam logic [TimeW-1:0] RstMinFlight = 32'd250000;
  localparam logic [TimeW-1:0] RstSettle    = 32'd500000;
  localparam logic [LenW-1:0]  RstMaxHeight = 16'd15360;
  localparam logic [LenW-1:0]  RstMaxDist   = 16'd64000;

  localparam logic OpFrame    = 1'b0;
  localparam logic OpAbort    = 1'b1;
  localparam logic RecTotals  = 1'b0;
  localparam logic RecMaxima  = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StSettle,
    StFlight,
    StDiff,
    StSqX,
    StSqZ,
    StSum,
    StRoot,
    StCheck,
    StEmit
  } ajm_state_t;

  typedef struct packed {
    logic           start;
    logic [SqW-1:0] radicand;
  } ajm_sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } ajm_sqrt_rsp_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

FILE: hw/rtl/ajm_in_if.sv
`timescale 1ns / 1ps

interface ajm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic                               airborne;
  logic signed [ajm_pkg::PosW-1:0]    pos_x;
  logic signed [ajm_pkg::PosW-1:0]    pos_y;
  logic signed [ajm_pkg::PosW-1:0]    pos_z;
  logic        [ajm_pkg::DtW-1:0]     frame_time_us;

  modport source (
    output valid, operation, airborne, pos_x, pos_y, pos_z, frame_time_us,
    input  ready
  );
  modport sink (
    input  valid, operation, airborne, pos_x, pos_y, pos_z, frame_time_us,
    output ready
  );
endinterface

FILE: hw/rtl/ajm_out_if.sv
`timescale 1ns / 1ps

interface ajm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         record_kind;
  logic [ajm_pkg::TimeW-1:0]    flight_time_us;
  logic [ajm_pkg::LenW-1:0]     jump_height;
  logic [ajm_pkg::LenW-1:0]     jump_distance;
  logic                         last_of_run;

  modport source (
    output valid, record_kind, flight_time_us, jump_height, jump_distance, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, record_kind, flight_time_us, jump_height, jump_distance, last_of_run,
    output ready
  );
endinterface

FILE: hw/rtl/ajm_isqrt.sv
`timescale 1ns / 1ps

module ajm_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ajm_pkg::ajm_sqrt_req_t req,
  output ajm_pkg::ajm_sqrt_rsp_t rsp
);

  logic [ajm_pkg::SqW-1:0]  rem_r, rem_nxt;
  logic [ajm_pkg::SqW:0]    root_r, root_nxt;
  logic [ajm_pkg::SqW-1:0]  bit_r, bit_nxt;
  logic [ajm_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [ajm_pkg::SqW:0]    trial;
  logic                     fits;

  assign trial = root_r + {1'b0, bit_r};
  assign fits  = {1'b0, rem_r} >= trial;

  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.radicand;
      root_nxt = '0;
      bit_nxt  = {1'b1, {(ajm_pkg::SqW-1){1'b0}}};
      cnt_nxt  = ajm_pkg::CntW'(ajm_pkg::RootW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt  = rem_r - trial[ajm_pkg::SqW-1:0];
        root_nxt = (root_r >> 1) + {1'b0, bit_r};
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r[ajm_pkg::RootW-1:0];

endmodule

FILE: hw/rtl/airtime_jump_measurer_top.sv
`timescale 1ns / 1ps

// Airtime jump measurer. Takes one telemetry or abort beat at a time; ready is high only
// while the block is idle. An abort returns to idle from its settle step; a frame that
// does not end a counted flight passes through the settle, flight and emit steps. A landing
// whose flight reaches the minimum airtime also passes the diff, square, sum, root and check
// steps: one shared 24x24 multiplier squares both offsets, then the 25-step bit-serial
// square root turns dx*dx + dz*dz into the distance. Up to two result beats per input
// leave through an output register; a stalled output holds the block in its emit step.

module airtime_jump_measurer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  ajm_in_if.sink                       in_ch,
  ajm_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [ajm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ajm_pkg::CfgW-1:0]     cfg_data
);

  localparam int unsigned PosW  = ajm_pkg::PosW;
  localparam int unsigned TimeW = ajm_pkg::TimeW;
  localparam int unsigned LenW  = ajm_pkg::LenW;

  ajm_pkg::ajm_state_t state_r, state_nxt;

  logic [TimeW-1:0] min_flight_r, settle_win_r;
  logic [LenW-1:0]  max_height_r, max_dist_r;

  logic                    op_r, op_nxt;
  logic                    air_r, air_nxt;
  logic signed [PosW-1:0]  px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [ajm_pkg::DtW-1:0] dt_r, dt_nxt;

  logic                    in_flight_r, in_flight_nxt;
  logic [TimeW-1:0]        air_time_r, air_time_nxt;
  logic signed [PosW-1:0]  tk_x_r, tk_x_nxt, tk_y_r, tk_y_nxt, tk_z_r, tk_z_nxt;
  logic signed [PosW-1:0]  peak_y_r, peak_y_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [TimeW-1:0]        settle_r, settle_nxt;
  logic [TimeW-1:0]        pend_time_r, pend_time_nxt;
  logic [LenW-1:0]         pend_h_r, pend_h_nxt, pend_d_r, pend_d_nxt;

  logic [TimeW-1:0]             secs_r, secs_nxt;
  logic [PosW-1:0]              ax_r, ax_nxt, az_r, az_nxt;
  logic signed [PosW:0]         h_r, h_nxt;
  logic [2*PosW-1:0]            sq_r, sq_nxt, acc_r, acc_nxt;
  logic [ajm_pkg::RootW-1:0]    dist_r, dist_nxt;
  logic                         emit_max_r, emit_max_nxt, emit_tot_r, emit_tot_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [TimeW-1:0]     out_time_r, out_time_nxt;
  logic [LenW-1:0]      out_h_r, out_h_nxt, out_d_r, out_d_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                  in_beat;
  logic                  out_free;
  logic [TimeW-1:0]      settle_sum;
  logic [TimeW-1:0]      dt_ext;
  logic signed [PosW:0]  dx, dz;
  logic [PosW-1:0]       mul_a;
  logic [2*PosW-1:0]     prod;
  logic                  jump_ok;

  ajm_pkg::ajm_sqrt_req_t sqrt_req;
  ajm_pkg::ajm_sqrt_rsp_t sqrt_rsp;

  ajm_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  assign in_ch.ready = (state_r == ajm_pkg::StIdle);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign dt_ext     = {{(TimeW-ajm_pkg::DtW){1'b0}}, dt_r};
  assign settle_sum = ajm_pkg::sat_add(settle_r, dt_ext);
  assign dx         = {px_r[PosW-1], px_r} - {tk_x_r[PosW-1], tk_x_r};
  assign dz         = {pz_r[PosW-1], pz_r} - {tk_z_r[PosW-1], tk_z_r};
  assign mul_a      = (state_r == ajm_pkg::StSqX) ? ax_r : az_r;
  assign prod       = {{PosW{1'b0}}, mul_a} * {{PosW{1'b0}}, mul_a};
  assign jump_ok    = !h_r[PosW]
                   && (h_r[PosW-1:0] < {{(PosW-LenW){1'b0}}, max_height_r})
                   && (dist_r < {{(ajm_pkg::RootW-LenW){1'b0}}, max_dist_r});

  assign sqrt_req.start    = (state_r == ajm_pkg::StSum);
  assign sqrt_req.radicand = {1'b0, acc_r} + {1'b0, sq_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ajm_pkg::StIdle:   if (in_beat) state_nxt = ajm_pkg::StSettle;
      ajm_pkg::StSettle: begin
        state_nxt = (op_r == ajm_pkg::OpAbort) ? ajm_pkg::StIdle : ajm_pkg::StFlight;
      end
      ajm_pkg::StFlight: begin
        if (!air_r && in_flight_r && (air_time_r >= min_flight_r)) begin
          state_nxt = ajm_pkg::StDiff;
        end else begin
          state_nxt = ajm_pkg::StEmit;
        end
      end
      ajm_pkg::StDiff:   state_nxt = ajm_pkg::StSqX;
      ajm_pkg::StSqX:    state_nxt = ajm_pkg::StSqZ;
      ajm_pkg::StSqZ:    state_nxt = ajm_pkg::StSum;
      ajm_pkg::StSum:    state_nxt = ajm_pkg::StRoot;
      ajm_pkg::StRoot:   if (sqrt_rsp.done) state_nxt = ajm_pkg::StCheck;
      ajm_pkg::StCheck:  state_nxt = ajm_pkg::StEmit;
      ajm_pkg::StEmit:   if (!emit_max_r && !emit_tot_r) state_nxt = ajm_pkg::StIdle;
      default:           state_nxt = ajm_pkg::StIdle;
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    air_nxt        = air_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    pz_nxt         = pz_r;
    dt_nxt         = dt_r;
    in_flight_nxt  = in_flight_r;
    air_time_nxt   = air_time_r;
    tk_x_nxt       = tk_x_r;
    tk_y_nxt       = tk_y_r;
    tk_z_nxt       = tk_z_r;
    peak_y_nxt     = peak_y_r;
    pend_valid_nxt = pend_valid_r;
    settle_nxt     = settle_r;
    pend_time_nxt  = pend_time_r;
    pend_h_nxt     = pend_h_r;
    pend_d_nxt     = pend_d_r;
    secs_nxt       = secs_r;
    ax_nxt         = ax_r;
    az_nxt         = az_r;
    h_nxt          = h_r;
    sq_nxt         = sq_r;
    acc_nxt        = acc_r;
    dist_nxt       = dist_r;
    emit_max_nxt   = emit_max_r;
    emit_tot_nxt   = emit_tot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_time_nxt   = out_time_r;
    out_h_nxt      = out_h_r;
    out_d_nxt      = out_d_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ajm_pkg::StIdle: begin
        if (in_beat) begin
          op_nxt       = in_ch.operation;
          air_nxt      = in_ch.airborne;
          px_nxt       = in_ch.pos_x;
          py_nxt       = in_ch.pos_y;
          pz_nxt       = in_ch.pos_z;
          dt_nxt       = in_ch.frame_time_us;
          emit_max_nxt = 1'b0;
          emit_tot_nxt = 1'b0;
        end
      end
      ajm_pkg::StSettle: begin
        if (op_r == ajm_pkg::OpAbort) begin
          in_flight_nxt  = 1'b0;
          air_time_nxt   = '0;
          pend_valid_nxt = 1'b0;
          settle_nxt     = '0;
        end else if (pend_valid_r) begin
          if (settle_sum >= settle_win_r) begin
            emit_max_nxt   = 1'b1;
            pend_valid_nxt = 1'b0;
            settle_nxt     = '0;
          end else begin
            settle_nxt = settle_sum;
          end
        end
      end
      ajm_pkg::StFlight: begin
        if (air_r) begin
          if (!in_flight_r) begin
            in_flight_nxt = 1'b1;
            air_time_nxt  = dt_ext;
            tk_x_nxt      = px_r;
            tk_y_nxt      = py_r;
            tk_z_nxt      = pz_r;
            peak_y_nxt    = py_r;
          end else begin
            air_time_nxt = ajm_pkg::sat_add(air_time_r, dt_ext);
            if (py_r > peak_y_r) peak_y_nxt = py_r;
          end
        end else if (in_flight_r) begin
          in_flight_nxt = 1'b0;
          air_time_nxt  = '0;
          secs_nxt      = air_time_r;
        end
      end
      ajm_pkg::StDiff: begin
        ax_nxt = dx[PosW] ? PosW'(-dx) : dx[PosW-1:0];
        az_nxt = dz[PosW] ? PosW'(-dz) : dz[PosW-1:0];
        h_nxt  = {peak_y_r[PosW-1], peak_y_r} - {tk_y_r[PosW-1], tk_y_r};
      end
      ajm_pkg::StSqX: begin
        sq_nxt = prod;
      end
      ajm_pkg::StSqZ: begin
        acc_nxt = sq_r;
        sq_nxt  = prod;
      end
      ajm_pkg::StSum: begin
      end
      ajm_pkg::StRoot: begin
        if (sqrt_rsp.done) dist_nxt = sqrt_rsp.root;
      end
      ajm_pkg::StCheck: begin
        if (jump_ok) begin
          emit_tot_nxt = 1'b1;
          if (pend_valid_r) emit_max_nxt = 1'b1;
        end
      end
      ajm_pkg::StEmit: begin
        if (out_free) begin
          priority if (emit_max_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = ajm_pkg::RecMaxima;
            out_time_nxt  = pend_time_r;
            out_h_nxt     = pend_h_r;
            out_d_nxt     = pend_d_r;
            out_last_nxt  = !emit_tot_r;
            emit_max_nxt  = 1'b0;
          end else if (emit_tot_r) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = ajm_pkg::RecTotals;
            out_time_nxt   = secs_r;
            out_h_nxt      = h_r[LenW-1:0];
            out_d_nxt      = dist_r[LenW-1:0];
            out_last_nxt   = 1'b1;
            emit_tot_nxt   = 1'b0;
            pend_valid_nxt = 1'b1;
            settle_nxt     = '0;
            pend_time_nxt  = secs_r;
            pend_h_nxt     = h_r[LenW-1:0];
            pend_d_nxt     = dist_r[LenW-1:0];
          end else begin
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ajm_pkg::StIdle;
      min_flight_r <= ajm_pkg::RstMinFlight;
      settle_win_r <= ajm_pkg::RstSettle;
      max_height_r <= ajm_pkg::RstMaxHeight;
      max_dist_r   <= ajm_pkg::RstMaxDist;
      in_flight_r  <= 1'b0;
      air_time_r   <= '0;
      tk_x_r       <= '0;
      tk_y_r       <= '0;
      tk_z_r       <= '0;
      peak_y_r     <= '0;
      pend_valid_r <= 1'b0;
      settle_r     <= '0;
      emit_max_r   <= 1'b0;
      emit_tot_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_flight_r  <= in_flight_nxt;
      air_time_r   <= air_time_nxt;
      tk_x_r       <= tk_x_nxt;
      tk_y_r       <= tk_y_nxt;
      tk_z_r       <= tk_z_nxt;
      peak_y_r     <= peak_y_nxt;
      pend_valid_r <= pend_valid_nxt;
      settle_r     <= settle_nxt;
      emit_max_r   <= emit_max_nxt;
      emit_tot_r   <= emit_tot_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ajm_pkg::CfgMinFlight: min_flight_r <= cfg_data[TimeW-1:0];
          ajm_pkg::CfgSettle:    settle_win_r <= cfg_data[TimeW-1:0];
          ajm_pkg::CfgMaxHeight: max_height_r <= cfg_data[LenW-1:0];
          ajm_pkg::CfgMaxDist:   max_dist_r   <= cfg_data[LenW-1:0];
          default: begin
          end
        endcase
      end
    end
    op_r        <= op_nxt;
    air_r       <= air_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    pz_r        <= pz_nxt;
    dt_r        <= dt_nxt;
    pend_time_r <= pend_time_nxt;
    pend_h_r    <= pend_h_nxt;
    pend_d_r    <= pend_d_nxt;
    secs_r      <= secs_nxt;
    ax_r        <= ax_nxt;
    az_r        <= az_nxt;
    h_r         <= h_nxt;
    sq_r        <= sq_nxt;
    acc_r       <= acc_nxt;
    dist_r      <= dist_nxt;
    out_kind_r  <= out_kind_nxt;
    out_time_r  <= out_time_nxt;
    out_h_r     <= out_h_nxt;
    out_d_r     <= out_d_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.record_kind    = out_kind_r;
  assign out_ch.flight_time_us = out_time_r;
  assign out_ch.jump_height    = out_h_r;
  assign out_ch.jump_distance  = out_d_r;
  assign out_ch.last_of_run    = out_last_r;

endmodule

FILE: hw/rtl/ajm_checker.sv
`timescale 1ns / 1ps

module ajm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [ajm_pkg::TimeW-1:0]   out_time,
  input logic [ajm_pkg::LenW-1:0]    out_height,
  input logic [ajm_pkg::LenW-1:0]    out_distance,
  input logic                        out_last
);

  // one beat at a time: a taken beat drops ready
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready stayed high after an accepted beat");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready)
      |=> $stable({out_kind, out_time, out_height, out_distance, out_last}))
    else $error("result payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid not cleared by reset");

endmodule

bind airtime_jump_measurer_top ajm_checker u_ajm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.record_kind),
  .out_time     (out_ch.flight_time_us),
  .out_height   (out_ch.jump_height),
  .out_distance (out_ch.jump_distance),
  .out_last     (out_ch.last_of_run)
);

FILE: tb/airtime_jump_measurer_top_tb.sv
`timescale 1ns / 1ps

module airtime_jump_measurer_top_tb;

  localparam int unsigned PosW    = ajm_pkg::PosW;
  localparam int unsigned DtW     = ajm_pkg::DtW;
  localparam int unsigned TimeW   = ajm_pkg::TimeW;
  localparam int unsigned LenW    = ajm_pkg::LenW;
  localparam int unsigned CfgW    = ajm_pkg::CfgW;
  localparam int unsigned CfgIdxW = ajm_pkg::CfgIdxW;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int          DrainCycles = 48;
  localparam int          SinkHold    = 300;
  localparam int          DirRows     = 26;

  typedef struct packed {
    logic                   op;
    logic                   air;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic [DtW-1:0]         dt;
  } frame_t;

  typedef struct packed {
    logic             kind;
    logic [TimeW-1:0] t;
    logic [LenW-1:0]  h;
    logic [LenW-1:0]  d;
    logic             last;
  } rec_t;

  typedef struct packed {
    frame_t     f;
    logic       fixed_exp;
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } dir_row_t;

  localparam dir_row_t NoFixed = '0;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;

  ajm_in_if  in_ch ();
  ajm_out_if out_ch ();

  airtime_jump_measurer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor copy of configuration and state
  logic [TimeW-1:0]       lim_flight, lim_settle;
  logic [LenW-1:0]        lim_height, lim_dist;
  logic                   in_air, pend_ok;
  logic [TimeW-1:0]       air_acc, settle_acc, pend_t;
  logic signed [PosW-1:0] to_x, to_y, to_z, peak_y;
  logic [LenW-1:0]        pend_h, pend_d;

  rec_t        pred_recs [2];
  int          pred_n;
  rec_t        records_due [$];
  dir_row_t    dir_tab [DirRows];
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          tight_left = 0;
  bit          park_sink = 1'b0;

  function automatic logic [TimeW-1:0] add_capped(input logic [TimeW-1:0] a,
                                                  input logic [TimeW-1:0] b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  function automatic longint floor_root(input longint v);
    longint r, c;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      c = r | (longint'(1) << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_predictor();
    lim_flight = ajm_pkg::RstMinFlight;
    lim_settle = ajm_pkg::RstSettle;
    lim_height = ajm_pkg::RstMaxHeight;
    lim_dist   = ajm_pkg::RstMaxDist;
    in_air     = 1'b0;
    pend_ok    = 1'b0;
    air_acc    = '0;
    settle_acc = '0;
    to_x       = '0;
    to_y       = '0;
    to_z       = '0;
    peak_y     = '0;
    pend_t     = '0;
    pend_h     = '0;
    pend_d     = '0;
  endtask

  task automatic predict_airtime(input frame_t f);
    longint           dx, dz, root;
    int               lift;
    logic [TimeW-1:0] secs;
    pred_n = 0;
    if (f.op == ajm_pkg::OpAbort) begin
      in_air     = 1'b0;
      air_acc    = '0;
      pend_ok    = 1'b0;
      settle_acc = '0;
    end else begin
      if (pend_ok) begin
        settle_acc = add_capped(settle_acc, TimeW'(f.dt));
        if (settle_acc >= lim_settle) begin
          pred_recs[pred_n] = '{ajm_pkg::RecMaxima, pend_t, pend_h, pend_d, 1'b0};
          pred_n++;
          pend_ok    = 1'b0;
          settle_acc = '0;
        end
      end
      if (f.air) begin
        if (!in_air) begin
          in_air  = 1'b1;
          air_acc = '0;
          to_x    = f.x;
          to_y    = f.y;
          to_z    = f.z;
          peak_y  = f.y;
        end
        air_acc = add_capped(air_acc, TimeW'(f.dt));
        if ($signed(f.y) > peak_y) peak_y = f.y;
      end else if (in_air) begin
        secs    = air_acc;
        in_air  = 1'b0;
        air_acc = '0;
        if (secs >= lim_flight) begin
          lift = int'(peak_y) - int'(to_y);
          dx   = longint'($signed(f.x)) - longint'(to_x);
          dz   = longint'($signed(f.z)) - longint'(to_z);
          root = floor_root(dx * dx + dz * dz);
          if (lift >= 0 && lift < int'(lim_height) && root < longint'(lim_dist)) begin
            if (pend_ok) begin
              pred_recs[pred_n] = '{ajm_pkg::RecMaxima, pend_t, pend_h, pend_d, 1'b0};
              pred_n++;
            end
            pred_recs[pred_n] = '{ajm_pkg::RecTotals, secs, LenW'(lift), LenW'(root),
                                  1'b0};
            pred_n++;
            pend_ok    = 1'b1;
            settle_acc = '0;
            pend_t     = secs;
            pend_h     = LenW'(lift);
            pend_d     = LenW'(root);
          end
        end
      end
    end
    if (pred_n > 0) pred_recs[pred_n-1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [TimeW-1:0] got,
                                 input logic [TimeW-1:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic offer_frame(input frame_t f, input dir_row_t fixed);
    int idle;
    if (tight_left > 0) begin
      idle = 0;
      tight_left--;
    end else begin
      idle = gap_len();
    end
    @(negedge clk);
    if (idle > 0) begin
      in_ch.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.operation     = f.op;
    in_ch.airborne      = f.air;
    in_ch.pos_x         = f.x;
    in_ch.pos_y         = f.y;
    in_ch.pos_z         = f.z;
    in_ch.frame_time_us = f.dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_airtime(f);
    if (fixed.fixed_exp) begin
      if (fixed.n > 0) records_due.push_back(fixed.r0);
      if (fixed.n > 1) records_due.push_back(fixed.r1);
    end else begin
      for (int i = 0; i < pred_n; i++) records_due.push_back(pred_recs[i]);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      ajm_pkg::CfgMinFlight: lim_flight = val;
      ajm_pkg::CfgSettle:    lim_settle = val;
      ajm_pkg::CfgMaxHeight: lim_height = val[LenW-1:0];
      ajm_pkg::CfgMaxDist:   lim_dist   = val[LenW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_config(input logic [TimeW-1:0] min_us, input logic [TimeW-1:0] win_us,
                             input logic [LenW-1:0] max_h, input logic [LenW-1:0] max_d);
    write_reg(ajm_pkg::CfgMinFlight, min_us);
    write_reg(ajm_pkg::CfgSettle, win_us);
    write_reg(ajm_pkg::CfgMaxHeight, CfgW'(max_h));
    write_reg(ajm_pkg::CfgMaxDist, CfgW'(max_d));
  endtask

  // drop valid, drain every due record, then let the block finish silent work
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic drive_random(input int items);
    int          sent, pick, k, shift, hspan, dspan, dx, dz;
    logic [23:0] bx, by, bz;
    frame_t      f;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 19) == 0) tight_left = $urandom_range(20, 80);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        bx    = 24'($urandom());
        by    = 24'($urandom());
        bz    = 24'($urandom());
        k     = $urandom_range(1, 6);
        shift = $urandom_range(0, 4);
        hspan = $urandom_range(0, 20000);
        dspan = $urandom_range(0, 46000);
        for (int i = 0; i < k; i++) begin
          f = '{ajm_pkg::OpFrame, 1'b1, (i == 0) ? bx : 24'($urandom()),
                (i == 0) ? by : by + 24'($urandom_range(0, hspan)),
                (i == 0) ? bz : 24'($urandom()),
                20'($urandom_range(0, 20'hFFFFF) >> shift)};
          offer_frame(f, NoFixed);
          sent++;
          if (i == 0 && $urandom_range(0, 11) == 0) begin
            f = '{ajm_pkg::OpAbort, 1'($urandom()), 24'($urandom()), 24'($urandom()),
                  24'($urandom()), 20'($urandom())};
            offer_frame(f, NoFixed);
            sent++;
          end
        end
        dx = $urandom_range(0, 2 * dspan) - dspan;
        dz = $urandom_range(0, 2 * dspan) - dspan;
        f  = '{ajm_pkg::OpFrame, 1'b0, bx + 24'(dx), 24'($urandom()), bz + 24'(dz),
               20'($urandom())};
        offer_frame(f, NoFixed);
        sent++;
        shift = $urandom_range(0, 4);
        repeat ($urandom_range(0, 3)) begin
          f = '{ajm_pkg::OpFrame, 1'b0, 24'($urandom()), 24'($urandom()), 24'($urandom()),
                20'($urandom_range(0, 20'hFFFFF) >> shift)};
          offer_frame(f, NoFixed);
          sent++;
        end
      end else begin
        f = '{(pick < 95) ? ajm_pkg::OpFrame : ajm_pkg::OpAbort, 1'($urandom()),
              24'($urandom()), 24'($urandom()), 24'($urandom()), 20'($urandom())};
        offer_frame(f, NoFixed);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : record_check
    rec_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.record_kind, out_ch.flight_time_us, out_ch.jump_height,
              out_ch.jump_distance, out_ch.last_of_run};
      if (records_due.size() == 0) begin
        report_mismatch("record with none due", got.t, '0);
      end else begin
        want = records_due.pop_front();
        if (got.kind !== want.kind) begin
          report_mismatch("record_kind", TimeW'(got.kind), TimeW'(want.kind));
        end
        if (got.t !== want.t) report_mismatch("flight_time_us", got.t, want.t);
        if (got.h !== want.h) report_mismatch("jump_height", TimeW'(got.h), TimeW'(want.h));
        if (got.d !== want.d) begin
          report_mismatch("jump_distance", TimeW'(got.d), TimeW'(want.d));
        end
        if (got.last !== want.last) begin
          report_mismatch("last_of_run", TimeW'(got.last), TimeW'(want.last));
        end
      end
    end
  end

  initial begin : result_sink
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (park_sink) begin
        out_ch.ready = 1'b0;
        for (int held = 0; held < SinkHold; held++) @(negedge clk);
        park_sink = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b0;
        repeat (gap_len()) @(negedge clk);
        out_ch.ready = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = ajm_pkg::OpFrame;
    in_ch.airborne      = 1'b0;
    in_ch.pos_x         = '0;
    in_ch.pos_y         = '0;
    in_ch.pos_z         = '0;
    in_ch.frame_time_us = '0;
    reset_predictor();

    dir_tab = '{
      '{'{ajm_pkg::OpAbort, 1'b0, 24'd0, 24'd0, 24'd0, 20'd0}, 1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'hFFFFF},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd0, 24'd0, 24'd0, 20'd100000},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd0, 24'd1000, 24'd0, 20'd150000},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'd768, 24'd0, 24'd1024, 20'd10000}, 1'b1, 2'd1,
        '{ajm_pkg::RecTotals, 32'd250000, 16'd1000, 16'd1280, 1'b1}, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'd0, 24'd0, 24'd0, 20'd499999},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'd0, 24'd0, 24'd0, 20'd1}, 1'b1, 2'd1,
        '{ajm_pkg::RecMaxima, 32'd250000, 16'd1000, 16'd1280, 1'b1}, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'h800000, 24'h800000, 24'h800000, 20'd249999},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'd0},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'h800000, 24'd0, 24'h800000, 20'hFFFFF},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'h7FFFFF, 24'd0, 24'h7FFFFF, 20'd0},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd0, 24'd0, 24'd0, 20'hFFFFF}, 1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd0, 24'd15360, 24'd0, 20'd0}, 1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'd0, 24'd0, 24'd0, 20'd0}, 1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd0, 24'd100, 24'd0, 20'd300000},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'd0, 24'd0, 24'd0, 20'd0}, 1'b1, 2'd1,
        '{ajm_pkg::RecTotals, 32'd300000, 16'd0, 16'd0, 1'b1}, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd0, 24'd0, 24'd0, 20'd300000},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd0, 24'd15359, 24'd0, 20'd0}, 1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'd63999, 24'd0, 24'd0, 20'd100000}, 1'b1, 2'd2,
        '{ajm_pkg::RecMaxima, 32'd300000, 16'd0, 16'd0, 1'b0},
        '{ajm_pkg::RecTotals, 32'd300000, 16'd15359, 16'd63999, 1'b1}},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd256, 24'd0, 24'd0, 20'd300000},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'd256, 24'd0, 24'd0, 20'd200000}, 1'b1, 2'd2,
        '{ajm_pkg::RecMaxima, 32'd300000, 16'd15359, 16'd63999, 1'b0},
        '{ajm_pkg::RecTotals, 32'd300000, 16'd0, 16'd0, 1'b1}},
      '{'{ajm_pkg::OpFrame, 1'b1, 24'd0, 24'd0, 24'd0, 20'd400000},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpAbort, 1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 20'hFFFFF},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, 24'd0, 24'd0, 24'd0, 20'd600000},
        1'b1, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b1, -24'sd1000, -24'sd2000, -24'sd3000, 20'd260000},
        1'b0, 2'd0, '0, '0},
      '{'{ajm_pkg::OpFrame, 1'b0, -24'sd4000, -24'sd1800, 24'sd5000, 20'd5},
        1'b0, 2'd0, '0, '0}
    };

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) offer_frame(dir_tab[i].f, dir_tab[i]);

    quiesce();
    load_config('0, '0, '1, '1);
    drive_random(450);

    quiesce();
    load_config($urandom_range(0, 2000000), $urandom_range(0, 3000000),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    park_sink = 1'b1;
    drive_random(450);

    quiesce();
    load_config('1, '1, '0, '0);
    drive_random(100);

    quiesce();
    load_config($urandom_range(0, 1500000), $urandom_range(0, 2500000),
                16'($urandom_range(20000, 65535)), 16'($urandom_range(20000, 65535)));
    drive_random(600);

    quiesce();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ajm_pkg.sv
hw/rtl/ajm_in_if.sv
hw/rtl/ajm_out_if.sv
hw/rtl/ajm_isqrt.sv
hw/rtl/airtime_jump_measurer_top.sv
hw/rtl/ajm_checker.sv
tb/airtime_jump_measurer_top_tb.sv
